// File: sv/rrc_pkg.sv
`default_nettype none

package rrc_pkg;

    // fixed field widths of the stream words
    localparam int KEY_W       = 64;
    localparam int SLOT_W      = 6;
    localparam int CAP_W       = 7;
    localparam int LFSR_W      = 32;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 72;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    // defaults for the top-level parameters
    localparam int DEF_DEPTH    = 64;
    localparam int DEF_KEY_BITS = 64;

    // register reset values and lfsr feedback
    localparam logic [CAP_W-1:0]  CAP_RESET  = 7'd64;
    localparam logic [LFSR_W-1:0] LFSR_RESET = 32'h0000_0001;
    localparam logic [LFSR_W-1:0] LFSR_TAPS  = 32'h8020_0003;

    // register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CAPACITY = 1'b0,
        REG_SEED     = 1'b1
    } rrc_reg_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MODULO,
        ST_RESULT
    } rrc_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic take_hit;
        logic take_append;
        logic take_replace;
        logic vic_read;
        logic commit;
    } rrc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic match;
        logic scan_end;
        logic full;
        logic mod_done;
        logic out_free;
    } rrc_stat_t;

    // one shift of the galois lfsr
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v >> 1;
        if (v[0])
        begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: sv/rrc_mod.sv
`default_nettype none

module rrc_mod #(
    parameter int DIV_W  = 7,
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]  divisor,
    output logic                   done,
    output logic [DIV_W-1:0]       rem
);

    localparam int STEP_W = $clog2(DATA_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DATA_W-1:0] dvd_reg;
    logic [DIV_W-1:0]  dvs_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W:0]    trial;
    logic [DIV_W-1:0]  rem_next;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DATA_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = DIV_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = DIV_W'(trial);
        end
    end

    // control of the step sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= STEP_W'(DATA_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // operand and remainder registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// File: sv/rrc_datapath.sv
`default_nettype none

module rrc_datapath #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [rrc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [rrc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic [rrc_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  wire logic                                m_tready,
    output logic                                     m_tvalid,
    output logic [rrc_pkg::OUT_TDATA_W-1:0]          m_tdata,
    input  wire rrc_pkg::rrc_cmd_t                   cmd,
    output rrc_pkg::rrc_stat_t                       stat
);

    import rrc_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [KEY_BITS-1:0]    mem [DEPTH];

    logic [CAP_W-1:0]       capacity_reg;
    logic [LFSR_W-1:0]      lfsr_reg;
    logic [LFSR_W-1:0]      lfsr_next;
    logic [KEY_BITS-1:0]    key_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic [CNT_W-1:0]       addr_reg;
    logic                   cmp_vld_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic [KEY_BITS-1:0]    rd_data_reg;
    logic                   hit_reg;
    logic                   evict_reg;
    logic [IDX_W-1:0]       slot_reg;
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic [CNT_W-1:0]       eff_cap;
    logic                   issue;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic                   mod_done;
    logic [CNT_W-1:0]       mod_rem;
    logic [KEY_W-1:0]       evict_word;
    logic [OUT_TDATA_W-1:0] result_word;

    // capacity in use, clamped to 1..DEPTH
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (CW'(capacity_reg) > CW'(DEPTH))
        begin
            eff_cap = CNT_W'(DEPTH);
        end
        else
        begin
            eff_cap = CNT_W'(capacity_reg);
        end
    end

    assign lfsr_next = lfsr_step(lfsr_reg);

    // victim index: advanced lfsr modulo capacity
    rrc_mod #(
        .DIV_W  (CNT_W),
        .DATA_W (LFSR_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.take_replace),
        .dividend (lfsr_next),
        .divisor  (eff_cap),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // key store port control
    assign issue   = cmd.scan && (addr_reg < fill_reg);
    assign rd_en   = issue || cmd.vic_read;
    assign rd_addr = cmd.vic_read ? mod_rem[IDX_W-1:0] : addr_reg[IDX_W-1:0];
    assign wr_en   = cmd.commit && !hit_reg;

    // key store, read-first with registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[slot_reg] <= key_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // configuration registers and lfsr
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            lfsr_reg     <= LFSR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CAPACITY: capacity_reg <= CAP_W'(cfg_wdata);
                REG_SEED:     lfsr_reg     <= (cfg_wdata == '0) ? LFSR_RESET
                                                                : LFSR_W'(cfg_wdata);
                default:      ;
            endcase
        end
        else if (cmd.take_replace)
        begin
            lfsr_reg <= lfsr_next;
        end
    end

    // request bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            addr_reg     <= '0;
            cmp_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            evict_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                addr_reg    <= '0;
                cmp_vld_reg <= 1'b0;
                hit_reg     <= 1'b0;
                evict_reg   <= 1'b0;
            end
            else if (cmd.scan)
            begin
                cmp_vld_reg <= issue;
                if (issue)
                begin
                    addr_reg <= addr_reg + 1'b1;
                end
            end
            if (cmd.take_hit)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.take_replace)
            begin
                evict_reg <= 1'b1;
            end
            if (cmd.commit && !hit_reg && !evict_reg)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg <= s_tdata[KEY_BITS-1:0];
        end
        if (issue)
        begin
            cmp_idx_reg <= addr_reg[IDX_W-1:0];
        end
        if (cmd.take_hit)
        begin
            slot_reg <= cmp_idx_reg;
        end
        else if (cmd.take_append)
        begin
            slot_reg <= fill_reg[IDX_W-1:0];
        end
        else if (cmd.vic_read)
        begin
            slot_reg <= mod_rem[IDX_W-1:0];
        end
        if (cmd.commit)
        begin
            m_tdata_reg <= result_word;
        end
    end

    // result word: hit, slot, evicted_valid, evicted_key from the lowest bit
    assign evict_word  = evict_reg ? KEY_W'(rd_data_reg) : '0;
    assign result_word = {evict_word, evict_reg, SLOT_W'(slot_reg), hit_reg};

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // status towards the controller
    always_comb
    begin
        stat.match    = cmp_vld_reg && (rd_data_reg == key_reg);
        stat.scan_end = !cmp_vld_reg && (addr_reg >= fill_reg);
        stat.full     = fill_reg >= eff_cap;
        stat.mod_done = mod_done;
        stat.out_free = !m_tvalid_reg || m_tready;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("lfsr locked at zero");

    a_victim_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.vic_read |-> (mod_rem < eff_cap) && (mod_rem < fill_reg))
        else $error("victim slot outside occupied range");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(hit_reg && evict_reg))
        else $error("hit and eviction in one result");

endmodule

`default_nettype wire

// File: sv/rrc_ctrl.sv
`default_nettype none

module rrc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire rrc_pkg::rrc_stat_t stat,
    output rrc_pkg::rrc_cmd_t       cmd
);

    import rrc_pkg::*;

    rrc_state_t state_reg;
    rrc_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (stat.match)
                begin
                    state_next = ST_RESULT;
                end
                else if (stat.scan_end)
                begin
                    state_next = stat.full ? ST_MODULO : ST_RESULT;
                end
            end
            ST_MODULO:
            begin
                if (stat.mod_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_SEARCH:
            begin
                cmd.scan = 1'b1;
                if (stat.match)
                begin
                    cmd.take_hit = 1'b1;
                end
                else if (stat.scan_end)
                begin
                    cmd.take_append  = !stat.full;
                    cmd.take_replace = stat.full;
                end
            end
            ST_MODULO:
            begin
                cmd.vic_read = stat.mod_done;
            end
            ST_RESULT:
            begin
                cmd.commit = stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/random_replacement_cache_unit.sv
`default_nettype none

// channel   dir   handshake           payload
// s_*       in    s_tvalid/s_tready   s_tdata: key
// m_*       out   m_tvalid/m_tready   m_tdata: hit, slot, evicted_valid, evicted_key
// cfg_*     in    cfg_we              cfg_addr: register index, cfg_wdata: value
//
// one request at a time; a lookup walks the occupied slots through the single
// key store read port: on a hit the walk stops at the matching slot, on a miss
// it covers every occupied slot (no walk with an empty store)
// a replacement adds 32 bit-serial modulo steps and one victim read
// reset empties the store at once (fill count zero, no clearing pass)
// a finished word waits in the output register; the next key is taken meanwhile

module random_replacement_cache_unit #(
    parameter int DEPTH    = rrc_pkg::DEF_DEPTH,
    parameter int KEY_BITS = rrc_pkg::DEF_KEY_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // key [63:0]
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [rrc_pkg::IN_TDATA_W-1:0]    s_tdata,
    // hit [0], slot [6:1], evicted_valid [7], evicted_key [71:8]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [rrc_pkg::OUT_TDATA_W-1:0]        m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [rrc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [rrc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    import rrc_pkg::*;

    rrc_cmd_t  cmd;
    rrc_stat_t stat;

    // sequencing
    rrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, lfsr, modulo and output register
    rrc_datapath #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
